/* hdl/hlf_pkg.sv */
// Shared types, constants and helper functions of the harmonic linker force block.
`timescale 1ns / 1ps
package hlf_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // segment fraction is always unsigned Q1.16
  localparam int           SEG_BITS = 16;
  localparam logic [16:0]  SEG_ONE  = 17'd65536;

  localparam int NUM_AXES    = 3;
  localparam int NUM_BEADS   = 4;
  localparam int STORE_DEPTH = 9;
  localparam int JOB_BEADS   = NUM_BEADS * NUM_AXES;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam int         CFG_IDX_W  = 1;
  localparam int         CFG_DATA_W = 32;
  localparam logic [0:0] REG_SPRING = 1'b0;
  localparam logic [0:0] REG_REST   = 1'b1;

  // bead slot codes
  localparam logic [1:0] SLOT_A0 = 2'd0;
  localparam logic [1:0] SLOT_A1 = 2'd1;
  localparam logic [1:0] SLOT_B0 = 2'd2;
  localparam logic [1:0] SLOT_B1 = 2'd3;

  typedef logic signed [31:0] coord_t;
  typedef logic [16:0]        frac_t;
  typedef logic signed [39:0] force_t;

  typedef struct packed {
    logic [1:0] bead_slot;
    coord_t     coord_x;
    coord_t     coord_y;
    coord_t     coord_z;
    frac_t      segment_fraction;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  target_slot;
    force_t      force_x;
    force_t      force_y;
    force_t      force_z;
    logic [47:0] stretch_energy;
    logic        zero_length;
    logic        last_of_run;
  } res_t;

  // one linker: all twelve coordinates and both fractions
  typedef struct packed {
    coord_t [JOB_BEADS-1:0] bead;
    frac_t                  frac0;
    frac_t                  frac1;
  } job_t;

  function automatic frac_t clamp_frac(frac_t p);
    return (p > SEG_ONE) ? SEG_ONE : p;
  endfunction

  // (a*(1-p) + b*p + half) >> 16, floored
  function automatic coord_t mid_point(coord_t a, coord_t b, frac_t p);
    logic signed [50:0] ax;
    logic signed [50:0] bx;
    logic signed [50:0] wa;
    logic signed [50:0] wb;
    logic signed [50:0] x;
    ax = 51'(a);
    bx = 51'(b);
    wa = $signed({34'd0, 17'(SEG_ONE - p)});
    wb = $signed({34'd0, p});
    x  = ax * wa + bx * wb + 51'sd32768;
    return coord_t'(x >>> SEG_BITS);
  endfunction

endpackage

/* hdl/hlf_front.sv */
// Front end: takes bead items, keeps the bead and fraction store, issues linker jobs.
`timescale 1ns / 1ps
module hlf_front (
  input  logic              clk,
  input  logic              in_valid,
  input  hlf_pkg::in_item_t in_item,
  output logic              in_stall,
  input  logic              q_full,
  output logic              push,
  output hlf_pkg::job_t     push_job
);
  import hlf_pkg::*;

  coord_t bead_r [STORE_DEPTH];
  frac_t  frac_r [2];
  logic   accept;
  coord_t coord [NUM_AXES];
  frac_t  frac_in;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign coord[0] = in_item.coord_x;
  assign coord[1] = in_item.coord_y;
  assign coord[2] = in_item.coord_z;
  assign frac_in  = clamp_frac(in_item.segment_fraction);
  assign push     = accept && (in_item.bead_slot == SLOT_B1);

  // store entries are undefined until written, so no reset
  always_ff @(posedge clk) begin
    if (accept && (in_item.bead_slot != SLOT_B1)) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        bead_r[4'(in_item.bead_slot) * 4'd3 + 4'(a)] <= coord[a];
      end
      if (in_item.bead_slot == SLOT_A0) begin
        frac_r[0] <= frac_in;
      end
      if (in_item.bead_slot == SLOT_B0) begin
        frac_r[1] <= frac_in;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      push_job.bead[i] = bead_r[i];
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      push_job.bead[STORE_DEPTH + a] = coord[a];
    end
    push_job.frac0 = frac_r[0];
    push_job.frac1 = frac_r[1];
  end

endmodule

/* hdl/hlf_queue.sv */
// Short job queue between the front end and the compute engine.
`timescale 1ns / 1ps
module hlf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hlf_pkg::job_t push_job,
  output logic          full,
  output logic          head_valid,
  output hlf_pkg::job_t head_job,
  input  logic          pop
);
  import hlf_pkg::*;

  job_t              job_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = job_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [QPTR_W-1:0] next_ptr(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      job_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= next_ptr(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= next_ptr(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* hdl/hlf_back.sv */
// Compute engine: points, distance, energy, unit vector and the four force results.
`timescale 1ns / 1ps
module hlf_back #(
  parameter int FRAC_BITS = hlf_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  hlf_pkg::job_t head_job,
  output logic          pop,
  input  logic [31:0]   spring_constant,
  input  logic [31:0]   rest_length,
  output logic          out_valid,
  output hlf_pkg::res_t out_item,
  input  logic          out_stall
);
  import hlf_pkg::*;

  localparam int ESHIFT = 2 * FRAC_BITS + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_MID, S_DIFF, S_SQRT, S_ELEN, S_PROD, S_ENER, S_ESAT,
    S_DIV, S_UW, S_MUL, S_FORCE, S_EMIT
  } state_t;

  state_t        state_r;
  logic [5:0]    cnt_r;
  job_t          job_r;
  coord_t        v1_r [NUM_AXES];
  coord_t        v2_r [NUM_AXES];
  logic [32:0]   dmag_r [NUM_AXES];
  logic          dneg_r [NUM_AXES];
  logic [65:0]   sum_r;
  logic [34:0]   rem_r;
  logic [32:0]   root_r;
  logic          e_neg_r;
  logic [32:0]   e_mag_r;
  logic          zero_r;
  logic [64:0]   p1_r;
  logic [47:0]   energy_r;
  logic [32:0]   dr_r [NUM_AXES];
  logic          dbit_r [NUM_AXES];
  logic [30:0]   q_r [NUM_AXES];
  logic [64:0]   mul_a_r;
  logic [63:0]   mul_b_r;
  logic [128:0]  acc_r;
  logic [1:0]    bead_r;
  logic [1:0]    axis_r;
  force_t        force_r [NUM_AXES];
  logic          out_valid_r;
  res_t          out_item_r;

  // midpoint lane: one point coordinate a cycle
  coord_t        mid_a;
  coord_t        mid_b;
  frac_t         mid_p;
  coord_t        mid_v;
  logic [1:0]    mid_axis;
  // difference and square
  logic [32:0]   dv;
  logic [32:0]   dmag;
  logic [65:0]   dsq;
  // square root step
  logic [36:0]   rem_sh;
  logic [36:0]   trial;
  logic          root_bit;
  // signed length error
  logic [33:0]   e_full;
  // serial multiplier step
  logic [80:0]   mprod;
  // force selection
  frac_t         p_sel;
  frac_t         w_sel;
  logic [30:0]   u_sel;
  logic [47:0]   uw;
  logic [63:0]   tension;
  logic          neg_sel;
  logic [128:0]  e_sh;
  logic          out_free;

  assign pop       = (state_r == S_IDLE) && head_valid;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    if (cnt_r < 6'd3) begin
      mid_axis = cnt_r[1:0];
      mid_a    = job_r.bead[cnt_r[1:0]];
      mid_b    = job_r.bead[4'd3 + 4'(cnt_r[1:0])];
      mid_p    = job_r.frac0;
    end else begin
      mid_axis = 2'(cnt_r - 6'd3);
      mid_a    = job_r.bead[4'd6 + 4'(mid_axis)];
      mid_b    = job_r.bead[4'd9 + 4'(mid_axis)];
      mid_p    = job_r.frac1;
    end
    mid_v = mid_point(mid_a, mid_b, mid_p);
  end

  always_comb begin
    dv   = 33'(v1_r[cnt_r[1:0]]) - 33'(v2_r[cnt_r[1:0]]);
    dmag = dv[32] ? 33'(0) - dv : dv;
    dsq  = 66'(dmag) * 66'(dmag);
  end

  always_comb begin
    rem_sh   = {rem_r, sum_r[65:64]};
    trial    = {2'b00, root_r, 2'b01};
    root_bit = (rem_sh >= trial);
  end

  assign e_full = {1'b0, root_r} - {2'b00, rest_length};
  assign mprod  = 81'(mul_a_r) * 81'(mul_b_r[63:48]);

  always_comb begin
    p_sel   = bead_r[1] ? job_r.frac1 : job_r.frac0;
    w_sel   = bead_r[0] ? p_sel : 17'(SEG_ONE - p_sel);
    u_sel   = zero_r ? '0 : q_r[axis_r];
    uw      = 48'(u_sel) * 48'(w_sel);
    tension = 64'(p1_r >> FRAC_BITS);
    neg_sel = e_neg_r ^ dneg_r[axis_r] ^ !bead_r[1];
    e_sh    = acc_r >> ESHIFT;
  end

  function automatic force_t sat_force(logic [82:0] m, logic neg);
    if (neg) begin
      if (m > 83'h80_0000_0000) begin
        return force_t'(40'h80_0000_0000);
      end
      return force_t'(40'd0 - m[39:0]);
    end
    if (m > 83'h7F_FFFF_FFFF) begin
      return force_t'(40'h7F_FFFF_FFFF);
    end
    return force_t'(m[39:0]);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      bead_r      <= '0;
      axis_r      <= '0;
    end else begin
      // in S_EMIT the output register is reloaded below instead
      if (out_valid_r && !out_stall && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (head_valid) begin
            job_r   <= head_job;
            cnt_r   <= '0;
            state_r <= S_MID;
          end
        end
        S_MID: begin
          if (cnt_r < 6'd3) begin
            v1_r[mid_axis] <= mid_v;
          end else begin
            v2_r[mid_axis] <= mid_v;
          end
          if (cnt_r == 6'd5) begin
            cnt_r   <= '0;
            sum_r   <= '0;
            state_r <= S_DIFF;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DIFF: begin
          dmag_r[cnt_r[1:0]] <= dmag;
          dneg_r[cnt_r[1:0]] <= dv[32];
          sum_r              <= sum_r + dsq;
          if (cnt_r == 6'd2) begin
            cnt_r   <= '0;
            rem_r   <= '0;
            root_r  <= '0;
            state_r <= S_SQRT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_SQRT: begin
          // one result bit per cycle, two radicand bits consumed
          rem_r  <= root_bit ? 35'(rem_sh - trial) : rem_sh[34:0];
          root_r <= {root_r[31:0], root_bit};
          sum_r  <= {sum_r[63:0], 2'b00};
          if (cnt_r == 6'd32) begin
            cnt_r   <= '0;
            state_r <= S_ELEN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_ELEN: begin
          e_neg_r <= e_full[33];
          e_mag_r <= e_full[33] ? 33'(34'd0 - e_full) : e_full[32:0];
          zero_r  <= (root_r == '0);
          for (int a = 0; a < NUM_AXES; a++) begin
            dr_r[a]   <= 33'(dmag_r[a] >> 1);
            dbit_r[a] <= dmag_r[a][0];
            q_r[a]    <= '0;
          end
          state_r <= S_PROD;
        end
        S_PROD: begin
          p1_r    <= 65'(spring_constant) * 65'(e_mag_r);
          mul_a_r <= 65'(spring_constant) * 65'(e_mag_r);
          mul_b_r <= 64'(e_mag_r);
          acc_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_ENER;
        end
        S_ENER, S_MUL: begin
          acc_r   <= (acc_r << 16) + 129'(mprod);
          mul_b_r <= mul_b_r << 16;
          if (cnt_r == 6'd3) begin
            cnt_r   <= '0;
            state_r <= (state_r == S_ENER) ? S_ESAT : S_FORCE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_ESAT: begin
          energy_r <= (|e_sh[128:48]) ? '1 : e_sh[47:0];
          state_r  <= S_DIV;
        end
        S_DIV: begin
          // three restoring dividers in lockstep, one quotient bit a cycle
          for (int a = 0; a < NUM_AXES; a++) begin
            if ({dr_r[a], dbit_r[a]} >= {1'b0, root_r}) begin
              dr_r[a] <= 33'({dr_r[a], dbit_r[a]} - {1'b0, root_r});
              q_r[a]  <= {q_r[a][29:0], 1'b1};
            end else begin
              dr_r[a] <= {dr_r[a][31:0], dbit_r[a]};
              q_r[a]  <= {q_r[a][29:0], 1'b0};
            end
            dbit_r[a] <= 1'b0;
          end
          if (cnt_r == 6'd30) begin
            cnt_r   <= '0;
            bead_r  <= '0;
            axis_r  <= '0;
            state_r <= S_UW;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_UW: begin
          mul_a_r <= 65'(uw);
          mul_b_r <= tension;
          acc_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_MUL;
        end
        S_FORCE: begin
          force_r[axis_r] <= sat_force(acc_r[128:46], neg_sel);
          if (axis_r == 2'd2) begin
            state_r <= S_EMIT;
          end else begin
            axis_r  <= axis_r + 1'b1;
            state_r <= S_UW;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r                <= 1'b1;
            out_item_r.target_slot     <= bead_r;
            out_item_r.force_x         <= force_r[0];
            out_item_r.force_y         <= force_r[1];
            out_item_r.force_z         <= force_r[2];
            out_item_r.stretch_energy  <= energy_r;
            out_item_r.zero_length     <= zero_r;
            out_item_r.last_of_run     <= (bead_r == SLOT_B1);
            axis_r                     <= '0;
            if (bead_r == SLOT_B1) begin
              state_r <= S_IDLE;
            end else begin
              bead_r  <= bead_r + 1'b1;
              state_r <= S_UW;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/harmonic_linker_force.sv */
// Top level of the harmonic linker force block: configuration registers and wiring.
`timescale 1ns / 1ps
// Harmonic linker force. Send the four beads of a linker as items on slots
// 0, 1, 2 and 3; slots 0 and 2 also carry the segment fraction (clamped to
// one). Slots 0..2 are written into the bead store. A slot 3 item hands a full
// snapshot of the linker to a two-entry job queue, and the compute engine
// then returns four results, beads 0..3 in order, the last one flagged.
// The engine works on one linker at a time and takes the next job only when
// idle. Its steps are point interpolation, squared distance, the bit-serial
// square root, the chunked 65x64 energy product, the three lockstep
// unit-vector dividers, and per force component one weight multiply plus
// four 16-bit chunks of the tension product, twelve components in all. The
// front end keeps taking beads while the engine works and stalls only when
// the queue holds two linkers. Results sit in an output register, so the
// engine moves on while a result waits. A zero distance sets zero_length
// and zeroes the forces; the energy is still reported. Write spring_constant
// and rest_length only while the block is idle. Reset is synchronous and
// active low; the bead store has no reset.
module harmonic_linker_force #(
  parameter int FRAC_BITS = hlf_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  hlf_pkg::in_item_t                in_item,
  output logic                             in_stall,
  output logic                             out_valid,
  output hlf_pkg::res_t                    out_item,
  input  logic                             out_stall,
  input  logic                             cfg_we,
  input  logic [hlf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hlf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import hlf_pkg::*;

  logic [31:0] spring_constant_r;
  logic [31:0] rest_length_r;

  logic        q_full;
  logic        push;
  job_t        push_job;
  logic        head_valid;
  job_t        head_job;
  logic        pop;

  // config write port, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spring_constant_r <= '0;
      rest_length_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPRING: spring_constant_r <= cfg_wdata;
        REG_REST:   rest_length_r     <= cfg_wdata;
      endcase
    end
  end

  // front end: bead store and job issue
  hlf_front u_front (
    .clk      (clk),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // decouples bead intake from the long per-linker computation
  hlf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  // compute engine with output register
  hlf_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_job        (head_job),
    .pop             (pop),
    .spring_constant (spring_constant_r),
    .rest_length     (rest_length_r),
    .out_valid       (out_valid),
    .out_item        (out_item),
    .out_stall       (out_stall)
  );

endmodule
